// ===== src/tsab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsab_pkg: shared types and constants of the sync-aligning byte buffer
// Transfer payloads, the classified command that crosses the queue, status
// codes and the back-end sequencer states.
// ----------------------------------------------------------------------------
package tsab_pkg;

  localparam int BufferBytesDefault = 8192;
  localparam int TsPacket           = 188;
  localparam int HuntSpan           = 3 * TsPacket;
  localparam int MaxPopBytes        = 512;
  localparam int WordBytes          = 8;
  localparam int QueueDepth         = 2;
  localparam int QPtrW              = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW              = $clog2(QueueDepth + 1);

  localparam logic [7:0] TsSync  = 8'h47;
  localparam logic       CmdPush = 1'b0;
  localparam logic       CmdPop  = 1'b1;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StNoSync = 2'd2,
    StShort  = 2'd3
  } status_e;

  typedef struct packed {
    logic        command;
    logic [63:0] push_data;
    logic [3:0]  push_count;
    logic [9:0]  request_length;
    logic [9:0]  room;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data;
    logic [3:0]  byte_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        command;
    logic [63:0] push_data;
    logic [3:0]  push_count;
    logic [9:0]  request_length;
    logic        push_bad;
    logic        req_bad;
    logic        req_zero;
  } cmd_t;

  typedef enum logic [3:0] {
    SIdle,
    SWrite,
    SHuntA,
    SHuntB,
    SHuntC,
    SHuntD,
    SCheckA,
    SCheckB,
    SDecide,
    SRead,
    SEmit,
    SSingle
  } back_state_e;

endpackage

// ===== src/tsab_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsab_ram: generic single-port-write RAM with registered read
// One write and one read per cycle; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module tsab_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tsab_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsab_front: input transfer acceptance and command classification
// Flags the checks that depend only on the item itself and hands the
// classified command to the queue.
// ----------------------------------------------------------------------------
module tsab_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsab_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output tsab_pkg::cmd_t    q_item_o
);
  import tsab_pkg::*;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.command        = in_item_i.command;
    q_item_o.push_data      = in_item_i.push_data;
    q_item_o.push_count     = in_item_i.push_count;
    q_item_o.request_length = in_item_i.request_length;
    q_item_o.push_bad       = (in_item_i.push_count == 4'd0) ||
                              (in_item_i.push_count > 4'(WordBytes));
    q_item_o.req_bad        = (in_item_i.request_length > 10'(MaxPopBytes)) ||
                              (in_item_i.room < in_item_i.request_length);
    q_item_o.req_zero       = (in_item_i.request_length == 10'd0);
  end

endmodule

// ===== src/tsab_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsab_queue: short command queue between front and back
// A small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
module tsab_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tsab_pkg::cmd_t item_i,
  output logic           full_o,
  output logic           valid_o,
  output tsab_pkg::cmd_t item_o,
  input  logic           pop_i
);
  import tsab_pkg::*;

  cmd_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== src/tsab_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsab_back: ring buffer sequencer
// Writes pushed bytes one per cycle, hunts for sync by reading the three
// candidate bytes (only the head byte when fewer than three packets are
// held), and streams popped bytes into 8-byte result words in an output register.
// ----------------------------------------------------------------------------
module tsab_back #(
  parameter int BufferBytes = tsab_pkg::BufferBytesDefault,
  parameter int AddrW       = $clog2(BufferBytes)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  tsab_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsab_pkg::out_item_t out_item_o,
  output logic                ram_we_o,
  output logic [AddrW-1:0]    ram_waddr_o,
  output logic [7:0]          ram_wdata_o,
  output logic [AddrW-1:0]    ram_raddr_o,
  input  logic [7:0]          ram_rdata_i
);
  import tsab_pkg::*;

  localparam int HeldW = $clog2(BufferBytes + 1);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [HeldW-1:0] held_q, held_d;
  logic [1:0]       status_q, status_d;
  logic [2:0]       wr_i_q, wr_i_d;
  logic             ok0_q, ok0_d, ok1_q, ok1_d, pend_q, pend_d;
  logic [9:0]       done_q, done_d;
  logic [3:0]       iss_q, iss_d, cap_q, cap_d;
  logic [63:0]      word_q, word_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             slot_free, is_last;
  logic [9:0]       left;
  logic [3:0]       word_n;

  function automatic logic [AddrW-1:0] wrap_add(logic [AddrW-1:0] a, logic [9:0] off);
    logic [AddrW:0] sum;
    sum = {1'b0, a} + (AddrW + 1)'(off);
    if (sum >= (AddrW + 1)'(BufferBytes)) begin
      sum = sum - (AddrW + 1)'(BufferBytes);
    end
    return sum[AddrW-1:0];
  endfunction

  assign slot_free   = !out_valid_q || out_ready_i;
  assign left        = cmd_q.request_length - done_q;
  assign word_n      = (left >= 10'(WordBytes)) ? 4'(WordBytes) : left[3:0];
  assign is_last     = ((done_q + 10'(word_n)) == cmd_q.request_length);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    head_d      = head_q;
    tail_d      = tail_q;
    held_d      = held_q;
    status_d    = status_q;
    wr_i_d      = wr_i_q;
    ok0_d       = ok0_q;
    ok1_d       = ok1_q;
    rd_ptr_d    = rd_ptr_q;
    done_d      = done_q;
    iss_d       = iss_q;
    cap_d       = cap_q;
    word_d      = word_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail_q;
    ram_wdata_o = cmd_q.push_data[wr_i_q*8 +: 8];
    ram_raddr_o = head_q;

    unique case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          wr_i_d    = '0;
          if (cmd_i.command == CmdPop) begin
            state_d = SHuntA;
          end else if (cmd_i.push_bad ||
                       (({1'b0, held_q} + (HeldW + 1)'(cmd_i.push_count)) >=
                        (HeldW + 1)'(BufferBytes))) begin
            status_d = StFull;
            state_d  = SSingle;
          end else begin
            state_d = SWrite;
          end
        end
      end
      SWrite: begin
        ram_we_o = 1'b1;
        tail_d   = wrap_add(tail_q, 10'd1);
        wr_i_d   = wr_i_q + 3'd1;
        if (({1'b0, wr_i_q} + 4'd1) == cmd_q.push_count) begin
          held_d   = held_q + HeldW'(cmd_q.push_count);
          status_d = StOk;
          state_d  = SSingle;
        end
      end
      SHuntA: begin
        if (held_q >= HeldW'(HuntSpan)) begin
          state_d = SHuntB;
        end else begin
          state_d = SCheckA;
        end
      end
      SHuntB: begin
        ram_raddr_o = wrap_add(head_q, 10'(TsPacket));
        ok0_d       = (ram_rdata_i == TsSync);
        state_d     = SHuntC;
      end
      SHuntC: begin
        ram_raddr_o = wrap_add(head_q, 10'(2 * TsPacket));
        ok1_d       = (ram_rdata_i == TsSync);
        state_d     = SHuntD;
      end
      SHuntD: begin
        if (ok0_q && ok1_q && (ram_rdata_i == TsSync)) begin
          state_d = SDecide;
        end else begin
          head_d  = wrap_add(head_q, 10'd1);
          held_d  = held_q - HeldW'(1);
          state_d = SHuntA;
        end
      end
      SCheckA: begin
        if (held_q == '0) begin
          status_d = StNoSync;
          state_d  = SSingle;
        end else begin
          state_d = SCheckB;
        end
      end
      SCheckB: begin
        if (ram_rdata_i != TsSync) begin
          status_d = StNoSync;
          state_d  = SSingle;
        end else begin
          state_d = SDecide;
        end
      end
      SDecide: begin
        if (cmd_q.req_bad || (held_q < HeldW'(cmd_q.request_length))) begin
          status_d = StShort;
          state_d  = SSingle;
        end else if (cmd_q.req_zero) begin
          status_d = StOk;
          state_d  = SSingle;
        end else begin
          rd_ptr_d = head_q;
          done_d   = '0;
          iss_d    = '0;
          cap_d    = '0;
          word_d   = '0;
          state_d  = SRead;
        end
      end
      SRead: begin
        ram_raddr_o = rd_ptr_q;
        if (iss_q < word_n) begin
          pend_d   = 1'b1;
          rd_ptr_d = wrap_add(rd_ptr_q, 10'd1);
          iss_d    = iss_q + 4'd1;
        end
        if (pend_q) begin
          word_d[cap_q[2:0]*8 +: 8] = ram_rdata_i;
          cap_d = cap_q + 4'd1;
          if ((cap_q + 4'd1) == word_n) begin
            state_d = SEmit;
          end
        end
      end
      SEmit: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.status     = StOk;
          out_d.data       = word_q;
          out_d.byte_count = word_n;
          out_d.last       = is_last;
          done_d           = done_q + 10'(word_n);
          iss_d            = '0;
          cap_d            = '0;
          word_d           = '0;
          if (is_last) begin
            head_d  = rd_ptr_q;
            held_d  = held_q - HeldW'(cmd_q.request_length);
            state_d = SIdle;
          end else begin
            state_d = SRead;
          end
        end
      end
      SSingle: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.status     = status_q;
          out_d.data       = '0;
          out_d.byte_count = '0;
          out_d.last       = 1'b1;
          state_d          = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      head_q      <= '0;
      tail_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    wr_i_q   <= wr_i_d;
    ok0_q    <= ok0_d;
    ok1_q    <= ok1_d;
    rd_ptr_q <= rd_ptr_d;
    done_q   <= done_d;
    iss_q    <= iss_d;
    cap_q    <= cap_d;
    word_q   <= word_d;
    out_q    <= out_d;
  end

endmodule

// ===== src/ts_sync_aligning_byte_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_sync_aligning_byte_buffer_core: transport-stream sync-aligning buffer
// Byte ring buffer that stores pushed bytes and, on a pop, hunts for three
// sync bytes one packet apart before delivering the requested block.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+---------------------------
//   in      | in_valid_i/in_ready_o  | in_item_i  (in_item_t)
//   out     | out_valid_o/out_ready_i| out_item_o (out_item_t)
//
// A push writes its bytes one at a time into the ring; a refused one only
// returns its status. A pop hunts for sync, dropping one byte per failed
// try through the single read port, before its length check; each result
// word is then read byte by byte and emitted, a refused pop gives one status word.
// Reset clears head, count and the queue; the byte store is not cleared.
// A stalled output holds the sequencer while the two-entry queue fills.
// ----------------------------------------------------------------------------
module ts_sync_aligning_byte_buffer_core #(
  parameter int BufferBytes = tsab_pkg::BufferBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tsab_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsab_pkg::out_item_t out_item_o
);
  import tsab_pkg::*;

  localparam int AddrW = $clog2(BufferBytes);

  cmd_t             front_cmd, queue_cmd;
  logic             q_push, q_full, q_valid, q_pop;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  tsab_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (front_cmd)
  );

  tsab_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (queue_cmd),
    .pop_i   (q_pop)
  );

  tsab_back #(
    .BufferBytes (BufferBytes),
    .AddrW       (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tsab_ram #(
    .Width (8),
    .Depth (BufferBytes),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_fail_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != StOk) |->
      (out_item_o.byte_count == 4'd0) && out_item_o.last)
    else $error("Failed result carries data or is not final.");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.byte_count <= 4'd8))
    else $error("Result byte count above eight.");

  a_full_words : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == StOk) && !out_item_o.last |->
      (out_item_o.byte_count == 4'd8))
    else $error("Non-final pop word is not full.");

endmodule

// ===== test/ts_sync_aligning_byte_buffer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_sync_aligning_byte_buffer_core_test: self-checking bench for the buffer
// A short table of directed transfers hits the empty, refused and short cases.
// A long receiver hold-off then stalls the input while most of the ring is
// filled with packet-aligned stream data. Random pushes and pops follow under
// four idling patterns.
// Every result transfer is compared field by field with a cycle-free
// prediction of the ring, the sync hunt and the word packing.
// ----------------------------------------------------------------------------
module ts_sync_aligning_byte_buffer_core_test;
  import tsab_pkg::*;

  // A 1024-byte ring lets the stimulus wrap the byte store.
  localparam int unsigned RingBytes     = 1024;
  localparam int unsigned HoldOffCycles = 1500;
  localparam int unsigned FillPushes    = 112;
  localparam int unsigned PhaseItems    = 10;
  localparam int unsigned DrainCycles   = 60;

  typedef struct packed {
    in_item_t item;
    logic     fixed;
    status_e  fixed_status;
  } table_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  logic [7:0]  ring_copy [RingBytes];
  int unsigned ring_head;
  int unsigned ring_held;

  out_item_t   predicted[$];
  out_item_t   expected_words[$];
  table_row_t  opening_table[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_req      = 1'b0;
  bit          hold_ack      = 1'b0;
  int unsigned stream_pos    = 0;
  int unsigned junk_left     = 0;

  int unsigned phase_idle  [4] = '{0, 81, 0, 26};
  int unsigned phase_stall [4] = '{0, 0, 81, 26};

  int unsigned mismatches     = 0;
  int unsigned transfers_sent = 0;
  int unsigned words_checked  = 0;
  int unsigned pushes_stored  = 0;
  int unsigned pushes_refused = 0;
  int unsigned pops_served    = 0;
  int unsigned pops_refused   = 0;
  int unsigned sync_slips     = 0;

  ts_sync_aligning_byte_buffer_core #(
    .BufferBytes(RingBytes)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] ring_byte(int unsigned offset);
    return ring_copy[(ring_head + offset) % RingBytes];
  endfunction

  function automatic void slip_head(int unsigned n);
    ring_head = (ring_head + n) % RingBytes;
    ring_held = ring_held - n;
  endfunction

  function automatic void predict_transfer(in_item_t it);
    out_item_t   w;
    int unsigned n;
    int unsigned req;
    int unsigned done;
    predicted.delete();
    w = '0;
    w.last = 1'b1;
    req = it.request_length;
    if (it.command == CmdPush) begin
      n = it.push_count;
      if (n == 0 || n > WordBytes || RingBytes - ring_held <= n) begin
        w.status = StFull;
        pushes_refused++;
      end else begin
        for (int i = 0; i < n; i++) begin
          ring_copy[(ring_head + ring_held + i) % RingBytes] = it.push_data[8*i +: 8];
        end
        ring_held += n;
        w.status = StOk;
        pushes_stored++;
      end
      predicted.push_back(w);
      return;
    end
    while (ring_held >= HuntSpan && !(ring_byte(0) == TsSync &&
           ring_byte(TsPacket) == TsSync && ring_byte(2 * TsPacket) == TsSync)) begin
      slip_head(1);
      sync_slips++;
    end
    if (ring_held == 0 || ring_byte(0) != TsSync) begin
      w.status = StNoSync;
    end else if (req > MaxPopBytes || it.room < req || ring_held < req) begin
      w.status = StShort;
    end else begin
      w.status = StOk;
    end
    if (w.status != StOk || req == 0) begin
      if (w.status == StOk) pops_served++;
      else pops_refused++;
      predicted.push_back(w);
      return;
    end
    for (done = 0; done < req; done += n) begin
      n = (req - done < WordBytes) ? req - done : WordBytes;
      w.data = '0;
      for (int i = 0; i < n; i++) begin
        w.data[8*i +: 8] = ring_byte(done + i);
      end
      w.byte_count = 4'(n);
      w.last = (done + n == req);
      predicted.push_back(w);
    end
    slip_head(req);
    pops_served++;
  endfunction

  function automatic logic [7:0] next_stream_byte();
    logic [7:0] b;
    if (junk_left > 0) begin
      junk_left--;
      return 8'($urandom);
    end
    b = (stream_pos == 0) ? TsSync : 8'($urandom);
    stream_pos = (stream_pos + 1) % TsPacket;
    if (stream_pos == 0 && $urandom_range(99) < 15) junk_left = $urandom_range(1, 30);
    return b;
  endfunction

  function automatic in_item_t push_of(logic [63:0] data, int unsigned count);
    in_item_t it;
    it.command        = CmdPush;
    it.push_data      = data;
    it.push_count     = 4'(count);
    it.request_length = 10'($urandom);
    it.room           = 10'($urandom);
    return it;
  endfunction

  function automatic in_item_t pop_of(int unsigned req, int unsigned room);
    in_item_t it;
    it.command        = CmdPop;
    it.push_data      = {$urandom, $urandom};
    it.push_count     = 4'($urandom);
    it.request_length = 10'(req);
    it.room           = 10'(room);
    return it;
  endfunction

  function automatic in_item_t stream_push(int unsigned count);
    logic [63:0] data;
    data = {$urandom, $urandom};
    for (int i = 0; i < WordBytes; i++) begin
      if (count <= WordBytes && i < count) data[8*i +: 8] = next_stream_byte();
    end
    return push_of(data, count);
  endfunction

  function automatic in_item_t random_item();
    int unsigned roll;
    int unsigned req;
    int unsigned room;
    roll = $urandom_range(99);
    if (roll < 78) begin
      roll = $urandom_range(99);
      if (roll < 4) return stream_push(0);
      if (roll < 8) return stream_push($urandom_range(WordBytes + 1, 15));
      if (roll < 55) return stream_push(WordBytes);
      return stream_push($urandom_range(1, WordBytes));
    end
    roll = $urandom_range(99);
    if (roll < 10) req = 0;
    else if (roll < 55) req = $urandom_range(1, 32);
    else if (roll < 70) req = TsPacket;
    else if (roll < 85) req = $urandom_range(0, MaxPopBytes);
    else req = $urandom_range(MaxPopBytes + 1, 1023);
    room = ($urandom_range(99) < 80) ? $urandom_range(req, 1023) : $urandom_range(0, 1023);
    return pop_of(req, room);
  endfunction

  function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  task automatic send_item(in_item_t it, logic fixed, status_e fixed_status);
    out_item_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    transfers_sent++;
    predict_transfer(it);
    if (fixed) begin
      w = '0;
      w.status = fixed_status;
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      foreach (predicted[k]) expected_words.push_back(predicted[k]);
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        out_ready_i <= 1'b0;
        for (int c = 0; c < HoldOffCycles; c++) @(posedge clk_i);
        hold_ack = hold_req;
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with none expected, expected nothing, actual %p",
                 $time, out_item_o);
      end else begin
        want = expected_words.pop_front();
        flag_field("status", want.status, out_item_o.status);
        flag_field("data", want.data, out_item_o.data);
        flag_field("byte_count", want.byte_count, out_item_o.byte_count);
        flag_field("last", want.last, out_item_o.last);
      end
    end
  end

  initial begin : stimulus
    ring_head = 0;
    ring_held = 0;
    opening_table = '{
      '{pop_of(0, 0), 1'b1, StNoSync},
      '{pop_of(MaxPopBytes, 1023), 1'b1, StNoSync},
      '{push_of('1, 0), 1'b1, StFull},
      '{push_of('0, WordBytes + 1), 1'b1, StFull},
      '{push_of('1, 15), 1'b1, StFull},
      '{push_of(64'hFFFF_FFFF_FFFF_FF47, WordBytes), 1'b1, StOk},
      '{push_of(64'hFFFF_FFFF_FFFF_FF00, 1), 1'b1, StOk},
      '{pop_of(MaxPopBytes + 1, 1023), 1'b1, StShort},
      '{pop_of(1023, 1023), 1'b1, StShort},
      '{pop_of(10, 1023), 1'b1, StShort},
      '{pop_of(5, 4), 1'b1, StShort},
      '{pop_of(0, 0), 1'b1, StOk},
      '{pop_of(9, 9), 1'b0, StOk},
      '{pop_of(1, 1023), 1'b1, StNoSync},
      '{push_of(64'h0123_4567_89AB_CD47, WordBytes), 1'b1, StOk},
      '{pop_of(1, 1), 1'b0, StOk},
      '{pop_of(0, 0), 1'b1, StNoSync}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening_table[r]) begin
      send_item(opening_table[r].item, opening_table[r].fixed, opening_table[r].fixed_status);
    end
    hold_req = ~hold_req;
    repeat (FillPushes) send_item(stream_push(WordBytes), 1'b0, StOk);
    send_item(stream_push(1), 1'b0, StOk);
    send_item(pop_of(MaxPopBytes, MaxPopBytes - 1), 1'b0, StOk);
    send_item(pop_of(MaxPopBytes, MaxPopBytes), 1'b0, StOk);
    send_item(pop_of(TsPacket, 1023), 1'b0, StOk);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      repeat (PhaseItems) send_item(random_item(), 1'b0, StOk);
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d transfers: %0d pushes stored, %0d refused, %0d pops served, %0d refused.",
             transfers_sent, pushes_stored, pushes_refused, pops_served, pops_refused);
    $display("Checked %0d result words; the sync hunt slipped %0d bytes.",
             words_checked, sync_slips);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
